@@ src/text_terminal_cursor_scroll_assert.svh @@
// assertion macros for the text terminal block
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked outside reset
`define TTCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttcs assertion failed");
// next-cycle implication, checked outside reset
`define TTCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttcs assertion failed");
`else
`define TTCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TTCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/ttcs_pkg.sv @@
// types, constants and helpers shared by the text terminal modules
package ttcs_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = ROWS * COLS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int CELL_W     = 16;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int ROW_IN_W   = 6;
  localparam int TAB_BLANKS = 4;
  localparam int TAB_K_W    = $clog2(TAB_BLANKS);

  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_BLANK    = 8'd32;
  localparam logic [7:0] COLOR_RESET = 8'd135;

  typedef enum logic [1:0] {
    OP_PUT_CUR = 2'd0,
    OP_PUT_XY  = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RDATA,
    S_TAB,
    S_WRAP,
    S_PUT,
    S_SWEEP,
    S_DRAIN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_IN_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(int'(row) * COLS + int'(col));
  endfunction

endpackage

@@ src/text_terminal_cursor_scroll.sv @@
// text terminal: cursor, scroll and clear over a character cell store
//
// in channel: one transaction is one command. in_tuser carries the opcode
// (put at cursor, put at column/row, read cell, clear screen); in_tdata carries
// the character and the column/row used by put at column/row and read.
// out channel: exactly one transaction per command with the read cell (zero
// unless reading), the cursor after the command and the scroll flag.
// cfg_wr_en/cfg_wr_data set the color byte used for new cells; write it only
// while no command is in flight.
// commands run one at a time from a single-port-write, registered-read ram.
// a scroll adds a row-by-row copy and clear a pass over the store, both made
// by the one write port walking every cell.
// after reset a clearing pass fills the store with blanks in the reset color;
// in_tready stays low until it ends, while config writes are taken as usual.
// a stalled receiver holds the result in the out register; the next command is
// accepted meanwhile and waits for that register before it is delivered.
module text_terminal_cursor_scroll (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], col_in[14:8], row_in[20:15], zero fill
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cell_value[15:0], cursor_row[20:16],
                                  // cursor_col[27:21], scrolled[28], zero fill
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  ttcs_pkg::mem_req_t              mem_req;
  logic [ttcs_pkg::CELL_W-1:0]     mem_rdata;

  ttcs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata)
  );

  ttcs_ram #(
    .DEPTH (ttcs_pkg::CELLS),
    .WIDTH (ttcs_pkg::CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ src/ttcs_ram.sv @@
// simple dual-port ram, one write and one registered read per cycle
module ttcs_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/ttcs_ctrl.sv @@
// sequencer: cursor state, cell store sweeps and result register
`include "text_terminal_cursor_scroll_assert.svh"
module ttcs_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [7:0]                     cfg_wr_data,
  output ttcs_pkg::mem_req_t             mem_req,
  input  logic [ttcs_pkg::CELL_W-1:0]    mem_rdata
);

  localparam logic [ttcs_pkg::COL_W-1:0]  COLS_C = ttcs_pkg::COL_W'(ttcs_pkg::COLS);
  localparam logic [ttcs_pkg::ROW_W-1:0]  ROWS_C = ttcs_pkg::ROW_W'(ttcs_pkg::ROWS);
  localparam logic [ttcs_pkg::ADDR_W-1:0] LAST_A = ttcs_pkg::ADDR_W'(ttcs_pkg::CELLS - 1);
  localparam logic [ttcs_pkg::ADDR_W-1:0] BOT_A  =
    ttcs_pkg::ADDR_W'(ttcs_pkg::CELLS - ttcs_pkg::COLS);
  localparam logic [ttcs_pkg::ADDR_W-1:0] COLS_A = ttcs_pkg::ADDR_W'(ttcs_pkg::COLS);

  ttcs_pkg::state_t                  state_r, state_nxt;
  ttcs_pkg::state_t                  ret_r, ret_nxt;
  ttcs_pkg::op_t                     op_r, op_nxt;
  logic [7:0]                        ch_r, ch_nxt;
  logic [ttcs_pkg::COL_W-1:0]        col_in_r, col_in_nxt;
  logic [ttcs_pkg::ROW_IN_W-1:0]     row_in_r, row_in_nxt;
  logic [ttcs_pkg::ROW_W-1:0]        row_r, row_nxt;
  logic [ttcs_pkg::COL_W-1:0]        col_r, col_nxt;
  logic [7:0]                        text_color_r, text_color_nxt;
  logic [7:0]                        fill_color_r, fill_color_nxt;
  logic [ttcs_pkg::ADDR_W-1:0]       idx_r, idx_nxt;
  logic                              copy_r, copy_nxt;
  logic [ttcs_pkg::TAB_K_W-1:0]      tab_k_r, tab_k_nxt;
  logic                              wr_pend_r, wr_pend_nxt;
  logic [ttcs_pkg::ADDR_W-1:0]       wr_addr_r, wr_addr_nxt;
  logic                              wr_blank_r, wr_blank_nxt;
  logic                              scrolled_r, scrolled_nxt;
  logic [ttcs_pkg::CELL_W-1:0]       cell_r, cell_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [31:0]                       out_data_r, out_data_nxt;

  logic                              xy_ok;
  logic                              printable;
  logic [ttcs_pkg::ROW_W-1:0]        row_w;
  logic [ttcs_pkg::COL_W-1:0]        col_w;
  ttcs_pkg::state_t                  after_wrap;

  assign in_tready  = (state_r == ttcs_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign xy_ok     = (col_in_r < COLS_C) &&
                     (row_in_r < ttcs_pkg::ROW_IN_W'(ttcs_pkg::ROWS));
  assign printable = (ch_r != ttcs_pkg::CH_NEWLINE) && (ch_r != ttcs_pkg::CH_TAB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ttcs_pkg::S_SWEEP;
      ret_r        <= ttcs_pkg::S_IDLE;
      row_r        <= '0;
      col_r        <= '0;
      text_color_r <= ttcs_pkg::COLOR_RESET;
      fill_color_r <= ttcs_pkg::COLOR_RESET;
      idx_r        <= '0;
      copy_r       <= 1'b0;
      wr_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      text_color_r <= text_color_nxt;
      fill_color_r <= fill_color_nxt;
      idx_r        <= idx_nxt;
      copy_r       <= copy_nxt;
      wr_pend_r    <= wr_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    ch_r       <= ch_nxt;
    col_in_r   <= col_in_nxt;
    row_in_r   <= row_in_nxt;
    tab_k_r    <= tab_k_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wr_blank_r <= wr_blank_nxt;
    scrolled_r <= scrolled_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    op_nxt         = op_r;
    ch_nxt         = ch_r;
    col_in_nxt     = col_in_r;
    row_in_nxt     = row_in_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    text_color_nxt = cfg_wr_en ? cfg_wr_data : text_color_r;
    fill_color_nxt = fill_color_r;
    idx_nxt        = idx_r;
    copy_nxt       = copy_r;
    tab_k_nxt      = tab_k_r;
    wr_pend_nxt    = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    wr_blank_nxt   = wr_blank_r;
    scrolled_nxt   = scrolled_r;
    cell_nxt       = cell_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    row_w          = row_r;
    col_w          = col_r;
    after_wrap     = printable ? ttcs_pkg::S_PUT : ttcs_pkg::S_RESP;

    mem_req = '0;
    // delayed write stage of a sweep: copy a cell up from the row below or lay a blank
    if (wr_pend_r) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = wr_addr_r;
      mem_req.wdata = wr_blank_r ? {fill_color_r, ttcs_pkg::CH_BLANK} : mem_rdata;
    end

    case (state_r)
      ttcs_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = ttcs_pkg::op_t'(in_tuser);
          ch_nxt       = in_tdata[7:0];
          col_in_nxt   = in_tdata[14:8];
          row_in_nxt   = in_tdata[20:15];
          scrolled_nxt = 1'b0;
          cell_nxt     = '0;
          state_nxt    = ttcs_pkg::S_EXEC;
        end
      end
      ttcs_pkg::S_EXEC: begin
        case (op_r)
          ttcs_pkg::OP_PUT_CUR: begin
            if (ch_r == ttcs_pkg::CH_TAB) begin
              tab_k_nxt = '0;
              state_nxt = ttcs_pkg::S_TAB;
            end else begin
              if (ch_r == ttcs_pkg::CH_NEWLINE) begin
                row_nxt = row_r + 1'b1;
                col_nxt = '0;
              end
              state_nxt = ttcs_pkg::S_WRAP;
            end
          end
          ttcs_pkg::OP_PUT_XY: begin
            if (xy_ok) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = ttcs_pkg::cell_addr(row_in_r, col_in_r);
              mem_req.wdata = {text_color_r, ch_r};
            end
            state_nxt = ttcs_pkg::S_RESP;
          end
          ttcs_pkg::OP_READ: begin
            if (xy_ok) begin
              mem_req.raddr = ttcs_pkg::cell_addr(row_in_r, col_in_r);
              state_nxt     = ttcs_pkg::S_RDATA;
            end else begin
              state_nxt = ttcs_pkg::S_RESP;
            end
          end
          ttcs_pkg::OP_CLEAR: begin
            row_nxt        = '0;
            col_nxt        = '0;
            idx_nxt        = '0;
            copy_nxt       = 1'b0;
            fill_color_nxt = text_color_r;
            ret_nxt        = ttcs_pkg::S_RESP;
            state_nxt      = ttcs_pkg::S_SWEEP;
          end
          default: begin
            state_nxt = ttcs_pkg::S_RESP;
          end
        endcase
      end
      ttcs_pkg::S_RDATA: begin
        cell_nxt  = mem_rdata;
        state_nxt = ttcs_pkg::S_RESP;
      end
      ttcs_pkg::S_TAB: begin
        // blanks past the last column are dropped
        if (col_r < COLS_C) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ttcs_pkg::cell_addr({1'b0, row_r}, col_r);
          mem_req.wdata = {text_color_r, ttcs_pkg::CH_BLANK};
        end
        col_nxt   = col_r + 1'b1;
        tab_k_nxt = tab_k_r + 1'b1;
        if (tab_k_r == ttcs_pkg::TAB_K_W'(ttcs_pkg::TAB_BLANKS - 1)) begin
          state_nxt = ttcs_pkg::S_WRAP;
        end
      end
      ttcs_pkg::S_WRAP: begin
        if (col_r >= COLS_C) begin
          row_w = row_r + 1'b1;
          col_w = '0;
        end
        col_nxt = col_w;
        if (row_w >= ROWS_C) begin
          row_nxt        = row_w - 1'b1;
          scrolled_nxt   = 1'b1;
          idx_nxt        = '0;
          copy_nxt       = 1'b1;
          fill_color_nxt = text_color_r;
          ret_nxt        = after_wrap;
          state_nxt      = ttcs_pkg::S_SWEEP;
        end else begin
          row_nxt   = row_w;
          state_nxt = after_wrap;
        end
      end
      ttcs_pkg::S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ttcs_pkg::cell_addr({1'b0, row_r}, col_r);
        mem_req.wdata = {text_color_r, ch_r};
        col_nxt       = col_r + 1'b1;
        state_nxt     = ttcs_pkg::S_RESP;
      end
      ttcs_pkg::S_SWEEP: begin
        // read the cell one row below and write it here next cycle, or lay a blank
        wr_pend_nxt  = 1'b1;
        wr_addr_nxt  = idx_r;
        wr_blank_nxt = !copy_r || (idx_r >= BOT_A);
        if (copy_r && (idx_r < BOT_A)) begin
          mem_req.raddr = idx_r + COLS_A;
        end
        if (idx_r == LAST_A) begin
          state_nxt = ttcs_pkg::S_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ttcs_pkg::S_DRAIN: begin
        state_nxt = ret_r;
      end
      ttcs_pkg::S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, scrolled_r, col_r, row_r, cell_r};
          state_nxt     = ttcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ttcs_pkg::S_IDLE;
      end
    endcase
  end

  `TTCS_ASSERT_NOW(a_wr_in_range, clk, rst_n, mem_req.we, mem_req.waddr <= LAST_A)
  `TTCS_ASSERT_NOW(a_cursor_idle, clk, rst_n, state_r == ttcs_pkg::S_IDLE, (row_r < ROWS_C) && (col_r <= COLS_C))
  `TTCS_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_tvalid && in_tready, state_r == ttcs_pkg::S_EXEC)
  `TTCS_ASSERT_NOW(a_pend_sweep, clk, rst_n, wr_pend_r, (state_r == ttcs_pkg::S_SWEEP) || (state_r == ttcs_pkg::S_DRAIN))

endmodule
